>>> rtl/adapter_mismatch_finder_macros.svh
// assertion macros for the adapter mismatch finder checker
`ifndef ADAPTER_MISMATCH_FINDER_MACROS_SVH
`define ADAPTER_MISMATCH_FINDER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define AMF_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define AMF_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/amf_pkg.sv
// ----------------------------------------------------------------------------
// amf_pkg
// shared constants and types for the adapter mismatch finder
// ----------------------------------------------------------------------------
package amf_pkg;

    localparam int READ_MAX    = 256;
    localparam int ADAPTER_MAX = 32;
    localparam int RA_W        = $clog2(READ_MAX);
    localparam int RC_W        = RA_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CHARS_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADP_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN  = 3'd6;

    // one queued word between front and back
    typedef struct packed {
        logic [RC_W-1:0] count;
        logic            overflow;
    } amf_job_t;

endpackage

>>> rtl/amf_front.sv
// ----------------------------------------------------------------------------
// amf_front
// accepts read bases, stores them and queues one job per finished read
// ----------------------------------------------------------------------------
module amf_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   base_char,
    input  logic                         last_base,
    // memory write side
    output logic                         wr_en,
    output logic [amf_pkg::RA_W-1:0]     wr_addr,
    output logic [7:0]                   wr_data,
    // job handoff
    output logic                         job_valid,
    output amf_pkg::amf_job_t            job,
    input  logic                         job_take
);

    logic [amf_pkg::RC_W-1:0] count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic                     busy_reg, busy_next;
    amf_pkg::amf_job_t        job_reg, job_next;
    logic                     accept;
    logic                     room;

    // one read at a time: hold while the back works on the stored read
    assign full   = busy_reg;
    assign accept = push && !busy_reg;
    assign room   = (count_reg < amf_pkg::RC_W'(amf_pkg::READ_MAX));

    assign wr_en   = accept && room;
    assign wr_addr = count_reg[amf_pkg::RA_W-1:0];
    assign wr_data = base_char;

    assign job_valid = busy_reg;
    assign job       = job_reg;

    // count, overflow and job capture
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        busy_next  = busy_reg;
        job_next   = job_reg;
        if (job_take)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            if (room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (last_base)
            begin
                job_next.count    = room ? count_reg + 1'b1 : count_reg;
                job_next.overflow = ovf_reg || !room;
                busy_next         = 1'b1;
                count_next        = '0;
                ovf_next          = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            job_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            busy_reg  <= busy_next;
            job_reg   <= job_next;
        end
    end

endmodule

>>> rtl/amf_back.sv
// ----------------------------------------------------------------------------
// amf_back
// searches the stored read for the adapter, one compare per cycle in compare states
// ----------------------------------------------------------------------------
module amf_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  amf_pkg::amf_job_t             job,
    output logic                          job_take,
    input  logic [255:0]                  adapter,
    input  logic [5:0]                    adapter_len,
    input  logic [5:0]                    max_mismatch,
    input  logic [5:0]                    min_match_len,
    // memory read side
    output logic [amf_pkg::RA_W-1:0]      rd_addr,
    input  logic [7:0]                    rd_data,
    // result queue
    output logic                          res_valid,
    input  logic                          res_take,
    output logic                          found,
    output logic [7:0]                    match_position,
    output logic                          overflow
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_FULL  = 4'd2;
    localparam logic [3:0] ST_FWAIT = 4'd3;
    localparam logic [3:0] ST_PSET  = 4'd4;
    localparam logic [3:0] ST_BDIV  = 4'd5;
    localparam logic [3:0] ST_PART  = 4'd6;
    localparam logic [3:0] ST_PWAIT = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam int PW = amf_pkg::RC_W + 1;

    logic [3:0]    st_reg, st_next;
    logic [5:0]    a_reg, a_next;
    logic [PW-1:0] left_reg, left_next;
    logic [PW-1:0] s_reg, s_next;
    logic [5:0]    c_reg, c_next;
    logic [6:0]    mis_reg, mis_next;
    logic [6:0]    bud_reg, bud_next;     // budget, max_mismatch minus quotient, see below
    logic          bneg_reg, bneg_next;
    logic [11:0]   num_reg, num_next;     // division remainder
    logic [6:0]    q_reg, q_next;
    logic [3:0]    dstep_reg, dstep_next;
    logic          ovf_reg, ovf_next;
    logic          rv_reg, rv_next;
    logic          fnd_reg, fnd_next;
    logic [7:0]    pos_reg, pos_next;
    logic          cmp_v_reg, cmp_v_next;
    logic [5:0]    cmp_c_reg, cmp_c_next;
    logic          take;

    logic [5:0]    den;
    logic [7:0]    adp_char;
    logic          mism;
    logic [PW-1:0] pos_full;

    assign den      = a_reg - min_match_len;
    assign adp_char = adapter[cmp_c_reg*8 +: 8];
    assign mism     = cmp_v_reg && (adp_char != rd_data);
    assign take     = (st_reg == ST_IDLE) && job_valid && !rv_reg;
    assign job_take = (st_reg == ST_DONE);

    assign res_valid      = rv_reg;
    assign found          = fnd_reg;
    assign match_position = pos_reg;
    assign overflow       = ovf_reg;

    // address of the character under compare
    always_comb
    begin
        if (st_reg == ST_PART)
        begin
            rd_addr = amf_pkg::RA_W'(left_reg + s_reg + PW'(c_reg));
        end
        else
        begin
            rd_addr = amf_pkg::RA_W'(s_reg + PW'(c_reg));
        end
    end

    // search sequencer
    always_comb
    begin
        st_next    = st_reg;
        a_next     = a_reg;
        left_next  = left_reg;
        s_next     = s_reg;
        c_next     = c_reg;
        mis_next   = mis_reg + 7'(mism);
        bud_next   = bud_reg;
        bneg_next  = bneg_reg;
        num_next   = num_reg;
        q_next     = q_reg;
        dstep_next = dstep_reg;
        ovf_next   = ovf_reg;
        rv_next    = rv_reg && !res_take;
        fnd_next   = fnd_reg;
        pos_next   = pos_reg;
        cmp_v_next = 1'b0;
        cmp_c_next = c_reg;
        pos_full   = '0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    a_next    = (adapter_len > 6'd32) ? 6'd32 : adapter_len;
                    left_next = PW'(job.count);
                    ovf_next  = job.overflow;
                    st_next   = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                s_next   = '0;
                c_next   = '0;
                mis_next = '0;
                if (left_reg < PW'(a_reg))
                begin
                    fnd_next = 1'b0;
                    pos_next = '0;
                    st_next  = ST_DONE;
                end
                else
                begin
                    left_next = left_reg - PW'(a_reg);
                    st_next   = (a_reg == 6'd0) ? ST_FWAIT : ST_FULL;
                end
            end
            ST_FULL:
            begin
                // issue compare c of start s
                cmp_v_next = 1'b1;
                cmp_c_next = c_reg;
                c_next     = c_reg + 1'b1;
                if (c_reg + 1'b1 == a_reg)
                begin
                    st_next = ST_FWAIT;
                end
            end
            ST_FWAIT:
            begin
                // wait for last compare to land in mis_next
                if (!cmp_v_reg)
                begin
                    if (mis_reg <= 7'(max_mismatch))
                    begin
                        fnd_next = 1'b1;
                        pos_full = s_reg;
                        pos_next = (pos_full > PW'(255)) ? 8'd255 : pos_full[7:0];
                        st_next  = ST_DONE;
                    end
                    else if (s_reg < left_reg)
                    begin
                        s_next   = s_reg + 1'b1;
                        c_next   = '0;
                        mis_next = '0;
                        st_next  = ST_FULL;
                    end
                    else if (min_match_len >= a_reg)
                    begin
                        fnd_next = 1'b0;
                        pos_next = '0;
                        st_next  = ST_DONE;
                    end
                    else
                    begin
                        s_next = PW'(1);
                        st_next = ST_PSET;
                    end
                end
            end
            ST_PSET:
            begin
                // numerator s*(mm+1)-1, then restoring division by den
                num_next   = 12'(s_reg[5:0] * (7'(max_mismatch) + 7'd1)) - 12'd1;
                q_next     = '0;
                dstep_next = '0;
                c_next     = '0;
                mis_next   = '0;
                st_next    = ST_BDIV;
            end
            ST_BDIV:
            begin
                // one quotient bit per cycle, seven bits suffice (quotient < 128)
                if (num_reg >= (12'(den) << (6 - dstep_reg)))
                begin
                    num_next = num_reg - (12'(den) << (6 - dstep_reg));
                    q_next   = q_reg | (7'd1 << (6 - dstep_reg));
                end
                dstep_next = dstep_reg + 1'b1;
                if (dstep_reg == 4'd6)
                begin
                    st_next = ST_PART;
                end
            end
            ST_PART:
            begin
                if (c_reg == 6'd0)
                begin
                    bneg_next = (q_reg > 7'(max_mismatch));
                    bud_next  = 7'(max_mismatch) - q_reg;
                end
                if (PW'(c_reg) + s_reg < PW'(a_reg))
                begin
                    cmp_v_next = 1'b1;
                    cmp_c_next = c_reg;
                    c_next     = c_reg + 1'b1;
                end
                else
                begin
                    st_next = ST_PWAIT;
                end
            end
            ST_PWAIT:
            begin
                if (!cmp_v_reg)
                begin
                    if (!bneg_reg && (mis_reg <= bud_reg))
                    begin
                        fnd_next = 1'b1;
                        pos_full = left_reg + s_reg;
                        pos_next = (pos_full > PW'(255)) ? 8'd255 : pos_full[7:0];
                        st_next  = ST_DONE;
                    end
                    else if (s_reg < PW'(a_reg - min_match_len) + PW'(1))
                    begin
                        s_next  = s_reg + 1'b1;
                        st_next = ST_PSET;
                    end
                    else
                    begin
                        fnd_next = 1'b0;
                        pos_next = '0;
                        st_next  = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                rv_next = 1'b1;
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            rv_reg    <= 1'b0;
            cmp_v_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            rv_reg    <= rv_next;
            cmp_v_reg <= cmp_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        left_reg  <= left_next;
        s_reg     <= s_next;
        c_reg     <= c_next;
        mis_reg   <= mis_next;
        bud_reg   <= bud_next;
        bneg_reg  <= bneg_next;
        num_reg   <= num_next;
        q_reg     <= q_next;
        dstep_reg <= dstep_next;
        ovf_reg   <= ovf_next;
        fnd_reg   <= fnd_next;
        pos_reg   <= pos_next;
        cmp_c_reg <= cmp_c_next;
    end

endmodule

>>> rtl/adapter_mismatch_finder.sv
// ----------------------------------------------------------------------------
// adapter_mismatch_finder
// finds a full or partial adapter match in a streamed read
// ----------------------------------------------------------------------------
// Usage: push read bases one word at a time with last_base on the final
// base; full is low while a read is being taken. One result word per read
// comes out on found, match_position and overflow, shown while empty is low
// and removed by pop. Configuration is written through cfg_we, cfg_index
// and cfg_data by the user while the block is idle; it does not enforce this.
// Input takes one base per cycle while full is low. After the last
// base the search runs on one shared compare unit, which reads the base
// store one character per cycle while it issues compares. The full stage
// tries each start in turn; each partial shift runs one setup, seven divide
// steps, the compare issue and a settle wait. full stays high from the last
// base until the search finishes.
// Reset clears the counters and empties the result register; the base store
// is not cleared. If pop stays low the result waits and the next read's
// search holds before taking its job.
// ----------------------------------------------------------------------------
module adapter_mismatch_finder
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         base_char,
    input  logic                               last_base,
    output logic                               empty,
    input  logic                               pop,
    output logic                               found,
    output logic [7:0]                         match_position,
    output logic                               overflow,
    input  logic                               cfg_we,
    input  logic [amf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [255:0]                adapter_reg;
    logic [5:0]                  adp_len_reg;
    logic [5:0]                  max_mm_reg;
    logic [5:0]                  min_len_reg;
    logic                        wr_en;
    logic [amf_pkg::RA_W-1:0]    wr_addr;
    logic [7:0]                  wr_data;
    logic [amf_pkg::RA_W-1:0]    rd_addr;
    logic [7:0]                  rd_data_reg;
    logic [7:0]                  store [amf_pkg::READ_MAX];
    logic                        job_valid;
    logic                        job_take;
    amf_pkg::amf_job_t           job;
    logic                        res_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapter_reg <= '0;
            adp_len_reg <= '0;
            max_mm_reg  <= '0;
            min_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                amf_pkg::REG_CHARS_0: adapter_reg[63:0]    <= cfg_data;
                amf_pkg::REG_CHARS_1: adapter_reg[127:64]  <= cfg_data;
                amf_pkg::REG_CHARS_2: adapter_reg[191:128] <= cfg_data;
                amf_pkg::REG_CHARS_3: adapter_reg[255:192] <= cfg_data;
                amf_pkg::REG_ADP_LEN: adp_len_reg <= cfg_data[5:0];
                amf_pkg::REG_MAX_MM:  max_mm_reg  <= cfg_data[5:0];
                amf_pkg::REG_MIN_LEN: min_len_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // read base store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
        rd_data_reg <= store[rd_addr];
    end

    amf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .base_char (base_char),
        .last_base (last_base),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    amf_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (job_valid),
        .job            (job),
        .job_take       (job_take),
        .adapter        (adapter_reg),
        .adapter_len    (adp_len_reg),
        .max_mismatch   (max_mm_reg),
        .min_match_len  (min_len_reg),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data_reg),
        .res_valid      (res_valid),
        .res_take       (pop),
        .found          (found),
        .match_position (match_position),
        .overflow       (overflow)
    );

    assign empty = !res_valid;

endmodule

>>> rtl/adapter_mismatch_finder_checker.sv
// ----------------------------------------------------------------------------
// adapter_mismatch_finder_checker
// port-level checks for the adapter mismatch finder
// ----------------------------------------------------------------------------
`include "adapter_mismatch_finder_macros.svh"

module adapter_mismatch_finder_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       last_base,
    input logic       empty,
    input logic       pop,
    input logic       found,
    input logic [7:0] match_position
);

    // a waiting word stays and its position holds until popped
    `AMF_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(match_position))
    // not found always reports position zero
    `AMF_ASSERT_IMP(a_nf_pos, clk, rst_n, !empty && !found, match_position == 8'd0)
    // an accepted last base closes the input by raising full
    `AMF_ASSERT_NEXT(a_last_full, clk, rst_n, push && !full && last_base, full)
    // a popped word is not seen again next cycle
    `AMF_ASSERT_NEXT(a_pop_gone, clk, rst_n, pop && !empty, empty)

endmodule

bind adapter_mismatch_finder adapter_mismatch_finder_checker u_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .last_base      (last_base),
    .empty          (empty),
    .pop            (pop),
    .found          (found),
    .match_position (match_position)
);
